### src/address_block_registry_unit_defines.svh
// Assertion macros shared by the registry RTL.
`ifndef ADDRESS_BLOCK_REGISTRY_UNIT_DEFINES_SVH
`define ADDRESS_BLOCK_REGISTRY_UNIT_DEFINES_SVH

// Same-cycle implication, checked on clock, off while reset is high.
`define ABRU_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("abru check failed");

// Next-cycle implication, checked on clock, off while reset is high.
`define ABRU_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("abru check failed");

`endif

### src/abru_pkg.sv
// Shared constants, types and the hash function of the block registry.
package abru_pkg;

   localparam int TABLE_DEPTH  = 4096;
   localparam int IDX_W        = $clog2(TABLE_DEPTH);
   localparam int ADDRESS_BITS = 48;
   localparam int HASH_SHIFT   = 16;
   localparam logic [63:0] HASH_MULT = 64'h9E3779B97F4A7C15;

   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_REMOVE = 2'd1;
   localparam logic [1:0] ACT_QUERY  = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_INVALID   = 2'd3;

   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_EXACT  = 2'd1;
   localparam logic [1:0] KIND_INSIDE = 2'd2;

   typedef enum logic [2:0] {
      RES_INVALID,
      RES_OK,
      RES_NOT_FOUND,
      RES_FULL,
      RES_EXACT,
      RES_INSIDE
   } res_sel_type;

   typedef struct packed {
      logic        load;
      logic        start_probe;
      logic        start_scan;
      logic        run;
      logic        clear;
      logic        wr_insert;
      logic        wr_remove;
      logic        set_res;
      res_sel_type res_sel;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0] act;
      logic       invalid;
      logic       rem_zero;
      logic       eval_valid;
      logic       free;
      logic       empty;
      logic       match;
      logic       contain;
      logic       last;
      logic       clear_done;
   } sts_type;

   // Only the low index bits of the 64-bit product are kept, so only the
   // low index bits of the operands take part.
   function automatic logic [IDX_W-1:0] home_slot(input logic [ADDRESS_BITS-1:0] a);
      logic [ADDRESS_BITS-1:0] v;
      logic [2*IDX_W-1:0]      p;
      v = a ^ (a >> HASH_SHIFT);
      p = v[IDX_W-1:0] * HASH_MULT[IDX_W-1:0];
      return p[IDX_W-1:0];
   endfunction

endpackage

### src/abru_ram.sv
// Generic single-write, single-read RAM with registered read data.
module abru_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/abru_ctrl.sv
// Controller state machine of the block registry.
`include "address_block_registry_unit_defines.svh"

module abru_ctrl
   import abru_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_PROBE,
      S_SCAN,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_tvalid_ff;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;

   always_comb begin
      cmd      = '0;
      cmd.res_sel = RES_INVALID;
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            if (sts.invalid) begin
               cmd.set_res = 1'b1;
               cmd.res_sel = RES_INVALID;
               state_in    = S_FINISH;
            end else if (sts.rem_zero) begin
               cmd.set_res = 1'b1;
               cmd.res_sel = RES_OK;
               state_in    = S_FINISH;
            end else begin
               cmd.start_probe = 1'b1;
               state_in        = S_PROBE;
            end
         end
         S_PROBE: begin
            cmd.run = 1'b1;
            if (sts.eval_valid) begin
               case (sts.act)
                  ACT_INSERT: begin
                     if (sts.free) begin
                        cmd.wr_insert = 1'b1;
                        cmd.set_res   = 1'b1;
                        cmd.res_sel   = RES_OK;
                        state_in      = S_FINISH;
                     end else if (sts.last) begin
                        cmd.set_res = 1'b1;
                        cmd.res_sel = RES_FULL;
                        state_in    = S_FINISH;
                     end
                  end
                  ACT_REMOVE: begin
                     if (sts.empty || (sts.last && !sts.match)) begin
                        cmd.set_res = 1'b1;
                        cmd.res_sel = RES_NOT_FOUND;
                        state_in    = S_FINISH;
                     end else if (sts.match) begin
                        cmd.wr_remove = 1'b1;
                        cmd.set_res   = 1'b1;
                        cmd.res_sel   = RES_OK;
                        state_in      = S_FINISH;
                     end
                  end
                  default: begin
                     if (sts.match) begin
                        cmd.set_res = 1'b1;
                        cmd.res_sel = RES_EXACT;
                        state_in    = S_FINISH;
                     end else if (sts.empty || sts.last) begin
                        // exact lookup missed: sweep for a containing block
                        cmd.run        = 1'b0;
                        cmd.start_scan = 1'b1;
                        state_in       = S_SCAN;
                     end
                  end
               endcase
            end
         end
         S_SCAN: begin
            cmd.run = 1'b1;
            if (sts.eval_valid) begin
               if (sts.contain) begin
                  cmd.set_res = 1'b1;
                  cmd.res_sel = RES_INSIDE;
                  state_in    = S_FINISH;
               end else if (sts.last) begin
                  cmd.set_res = 1'b1;
                  cmd.res_sel = RES_NOT_FOUND;
                  state_in    = S_FINISH;
               end
            end
         end
         S_FINISH: begin
            // hold until the output register is free
            if (!rsp_tvalid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.out_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   `ABRU_ASSERT_NEXT(a_accept_hash, req_tvalid && req_tready, state_ff == S_HASH)
   `ABRU_ASSERT_SAME(a_write_on_eval, cmd.wr_insert || cmd.wr_remove, sts.eval_valid)
   `ABRU_ASSERT_SAME(a_insert_action, cmd.wr_insert, sts.act == ACT_INSERT)
   `ABRU_ASSERT_NEXT(a_finish_loads, cmd.out_load, rsp_tvalid)

endmodule

### src/abru_dp.sv
// Datapath of the block registry: item registers, probe pipeline and slot RAMs.
module abru_dp
   import abru_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [95:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  cmd_type     cmd,
   output sts_type     sts,
   output logic [47:0] rsp_tdata,
   output logic [3:0]  rsp_tuser
);

   logic [1:0]              act_ff;
   logic [ADDRESS_BITS-1:0] addr_ff;
   logic [ADDRESS_BITS-1:0] size_ff;

   logic [IDX_W-1:0] iss_idx_ff;
   logic [IDX_W:0]   iss_cnt_ff;
   logic [IDX_W-1:0] evc_ff;
   logic             v1_ff, v2_ff;
   logic [IDX_W-1:0] idx1_ff, idx2_ff;

   logic                    used2_ff, tomb2_ff, eq2_ff, gt2_ff;
   logic [ADDRESS_BITS-1:0] diff2_ff, size2_ff;

   logic [1:0]              res_status_ff, res_kind_ff;
   logic [ADDRESS_BITS-1:0] res_size_ff;
   logic [1:0]              rsp_status_ff, rsp_kind_ff;
   logic [ADDRESS_BITS-1:0] rsp_size_ff;

   logic [2*ADDRESS_BITS-1:0] data_rd, data_wr;
   logic [1:0]                flag_rd, flag_wr;
   logic                      data_we, flag_we;
   logic [IDX_W-1:0]          wr_addr;
   logic                      issue;
   logic [ADDRESS_BITS-1:0]   ram_addr, ram_size;
   logic [ADDRESS_BITS:0]     diff_a, rem_b;

   abru_ram #(.WIDTH(2*ADDRESS_BITS), .DEPTH(TABLE_DEPTH)) u_data_ram (
      .clock   (clock),
      .wr_en   (data_we),
      .wr_addr (wr_addr),
      .wr_data (data_wr),
      .rd_addr (iss_idx_ff),
      .rd_data (data_rd)
   );

   // flag bits: [0] used, [1] tombstone
   abru_ram #(.WIDTH(2), .DEPTH(TABLE_DEPTH)) u_flag_ram (
      .clock   (clock),
      .wr_en   (flag_we),
      .wr_addr (wr_addr),
      .wr_data (flag_wr),
      .rd_addr (iss_idx_ff),
      .rd_data (flag_rd)
   );

   assign issue    = cmd.run && !iss_cnt_ff[IDX_W];
   assign ram_addr = data_rd[ADDRESS_BITS-1:0];
   assign ram_size = data_rd[2*ADDRESS_BITS-1:ADDRESS_BITS];
   assign diff_a   = {1'b0, addr_ff} - {1'b0, ram_addr};
   assign rem_b    = {1'b0, size2_ff} - {1'b0, diff2_ff};

   always_comb begin
      data_we = cmd.wr_insert;
      flag_we = cmd.wr_insert || cmd.wr_remove || cmd.clear;
      wr_addr = cmd.clear ? iss_idx_ff : idx2_ff;
      data_wr = {size_ff, addr_ff};
      if (cmd.wr_insert) begin
         flag_wr = 2'b01;
      end else if (cmd.wr_remove) begin
         flag_wr = 2'b10;
      end else begin
         flag_wr = 2'b00;
      end
   end

   always_comb begin
      sts.act        = act_ff;
      sts.invalid    = (act_ff != ACT_INSERT && act_ff != ACT_REMOVE && act_ff != ACT_QUERY)
                    || (act_ff == ACT_INSERT && (addr_ff == '0 || size_ff == '0))
                    || (act_ff == ACT_QUERY && addr_ff == '0);
      sts.rem_zero   = (act_ff == ACT_REMOVE) && (addr_ff == '0);
      sts.eval_valid = v2_ff;
      sts.free       = !used2_ff;
      sts.empty      = !used2_ff && !tomb2_ff;
      sts.match      = used2_ff && eq2_ff;
      sts.contain    = used2_ff && gt2_ff && !rem_b[ADDRESS_BITS]
                    && (rem_b[ADDRESS_BITS-1:0] != '0);
      sts.last       = &evc_ff;
      sts.clear_done = &iss_idx_ff;
   end

   // item and output registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff  <= req_tuser;
         addr_ff <= req_tdata[ADDRESS_BITS-1:0];
         size_ff <= req_tdata[2*ADDRESS_BITS-1:ADDRESS_BITS];
      end
      if (cmd.set_res) begin
         case (cmd.res_sel)
            RES_OK: begin
               res_status_ff <= ST_OK;
               res_kind_ff   <= KIND_NONE;
               res_size_ff   <= '0;
            end
            RES_NOT_FOUND: begin
               res_status_ff <= ST_NOT_FOUND;
               res_kind_ff   <= KIND_NONE;
               res_size_ff   <= '0;
            end
            RES_FULL: begin
               res_status_ff <= ST_FULL;
               res_kind_ff   <= KIND_NONE;
               res_size_ff   <= '0;
            end
            RES_EXACT: begin
               res_status_ff <= ST_OK;
               res_kind_ff   <= KIND_EXACT;
               res_size_ff   <= size2_ff;
            end
            RES_INSIDE: begin
               res_status_ff <= ST_OK;
               res_kind_ff   <= KIND_INSIDE;
               res_size_ff   <= rem_b[ADDRESS_BITS-1:0];
            end
            default: begin
               res_status_ff <= ST_INVALID;
               res_kind_ff   <= KIND_NONE;
               res_size_ff   <= '0;
            end
         endcase
      end
      if (cmd.out_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_kind_ff   <= res_kind_ff;
         rsp_size_ff   <= res_size_ff;
      end
   end

   // probe pipeline: issue read, register RAM data with first subtract, evaluate
   always_ff @(posedge clock) begin
      if (reset) begin
         iss_idx_ff <= '0;
         iss_cnt_ff <= '0;
         evc_ff     <= '0;
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
      end else if (cmd.start_probe || cmd.start_scan) begin
         iss_idx_ff <= cmd.start_probe ? home_slot(addr_ff) : '0;
         iss_cnt_ff <= '0;
         evc_ff     <= '0;
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
      end else if (cmd.clear) begin
         iss_idx_ff <= iss_idx_ff + 1'b1;
      end else if (cmd.run) begin
         if (issue) begin
            iss_idx_ff <= iss_idx_ff + 1'b1;
            iss_cnt_ff <= iss_cnt_ff + 1'b1;
         end
         if (v2_ff) begin
            evc_ff <= evc_ff + 1'b1;
         end
         v1_ff <= issue;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.run) begin
         idx1_ff  <= iss_idx_ff;
         idx2_ff  <= idx1_ff;
         used2_ff <= flag_rd[0];
         tomb2_ff <= flag_rd[1];
         eq2_ff   <= (ram_addr == addr_ff);
         gt2_ff   <= !diff_a[ADDRESS_BITS] && (diff_a[ADDRESS_BITS-1:0] != '0);
         diff2_ff <= diff_a[ADDRESS_BITS-1:0];
         size2_ff <= ram_size;
      end
   end

   assign rsp_tdata = rsp_size_ff;
   assign rsp_tuser = {rsp_kind_ff, rsp_status_ff};

endmodule

### src/address_block_registry_unit.sv
// Top level of the block registry: controller plus datapath.
//
// Registry of allocated blocks in a 4096-slot open-addressed hash table.
// Input beats on req_*: req_tuser carries the action (insert, remove, query),
// req_tdata the address and block size. Each beat yields one result beat on
// rsp_*: rsp_tuser carries status and hit kind, rsp_tdata the result size.
// One item is worked on at a time; req_tready is high only while idle.
// Rejected arguments and removes of address 0 finish without probing; other
// items probe one slot per cycle through the slot RAM's single read port.
// A query that misses its exact lookup then sweeps the table from slot 0,
// again one slot per cycle.
// After reset a clearing pass writes the flags of all 4096 slots, one slot per
// cycle; no beat is accepted during it.
// A finished result sits in an output register; the next item is accepted
// and processed while it waits, and only its own result holds until rsp_tready.
module address_block_registry_unit
   import abru_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // address[47:0], block_size[95:48]
   input  logic [1:0]  req_tuser,   // action[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // result_size[47:0]
   output logic [3:0]  rsp_tuser    // status[1:0], hit_kind[3:2]
);

   cmd_type cmd;
   sts_type sts;

   abru_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   abru_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule
